// ===== sv/sfr_pkg.sv =====
// ============================================================================
// sfr_pkg: shared types and constants for the stream find/replace block
// Beat payloads, front-to-back command flags, register indexes and helpers.
// ============================================================================
package sfr_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_BYTES = 3'd3;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Input beat
    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } in_t;

    // Result beat
    typedef struct packed {
        logic [7:0] out_char;
        logic       out_empty;
        logic       out_last;
    } out_t;

    // Flags of one queued command
    typedef struct packed {
        logic use_repl;  // emit replacement bytes rather than window bytes
        logic last;      // command closes the text
    } cmd_ctrl_t;

    // Byte i of a 64-bit register, zero at and beyond byte 8
    function automatic logic [7:0] reg_byte(input logic [63:0] r, input int unsigned i);
        reg_byte = 8'(r >> (8 * i));
    endfunction

endpackage

// ===== sv/sfr_front.sv =====
// ============================================================================
// sfr_front: window update and classification
// Append each accepted byte to the window, test the pattern and issue at most
// one command describing the bytes to emit.
// ============================================================================
module sfr_front
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN = 8,
    parameter int MAX_REPLACE = 8,
    localparam int LW      = $clog2(MAX_PATTERN + 1),
    localparam int MAX_OUT = (MAX_PATTERN > MAX_REPLACE) ? MAX_PATTERN : MAX_REPLACE,
    localparam int NW      = $clog2(MAX_OUT + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     take,
    input  in_t                      item,
    input  logic [3:0]               pattern_len,
    input  logic [63:0]              pattern_bytes,
    input  logic [3:0]               replace_len,
    output logic                     cmd_push,
    output cmd_ctrl_t                cmd_ctrl,
    output logic [NW-1:0]            cmd_n,
    output logic [MAX_PATTERN*8-1:0] cmd_bytes
);

    logic [7:0]    window_reg [MAX_PATTERN];
    logic [7:0]    window_next [MAX_PATTERN];
    logic [LW-1:0] count_reg;
    logic [LW-1:0] count_next;

    logic [7:0]    w [MAX_PATTERN];
    logic [LW-1:0] cnt_eff;
    logic [LW-1:0] cnt1;
    logic [LW-1:0] plen;
    logic [LW-1:0] keep;
    logic [LW-1:0] sh;
    logic [NW-1:0] rlen;
    logic [NW-1:0] n;
    logic          match;
    logic          use_repl;

    always_comb
    begin
        cnt_eff = (count_reg >= LW'(MAX_PATTERN)) ? LW'(MAX_PATTERN - 1) : count_reg;
        cnt1    = cnt_eff + 1'b1;

        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            w[i] = (i == int'(cnt_eff)) ? item.in_char : window_reg[i];
        end

        if ({2'b00, pattern_len} > 6'(MAX_PATTERN))
            plen = LW'(MAX_PATTERN);
        else
            plen = LW'(pattern_len);

        if ({2'b00, replace_len} > 6'(MAX_REPLACE))
            rlen = NW'(MAX_REPLACE);
        else
            rlen = NW'(replace_len);

        keep = (plen != '0) ? plen - 1'b1 : '0;

        match = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (i < int'(plen) && w[i] != reg_byte(pattern_bytes, i))
                match = 1'b0;
        end

        sh         = '0;
        n          = '0;
        use_repl   = 1'b0;
        count_next = cnt1;

        if (cnt1 > plen)
        begin
            // window overlong: release the oldest bytes unmatched
            sh         = cnt1 - keep;
            n          = NW'(cnt1 - keep);
            count_next = keep;
        end
        else if (cnt1 == plen)
        begin
            if (match)
            begin
                use_repl   = 1'b1;
                n          = rlen;
                count_next = '0;
            end
            else
            begin
                sh         = LW'(1);
                n          = NW'(1);
                count_next = cnt1 - 1'b1;
            end
        end

        if (item.in_last)
        begin
            // flush everything still pending
            count_next = '0;
            if (!use_repl)
                n = NW'(cnt1);
        end

        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            window_next[i] = w[i];
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                if (int'(sh) + i == j)
                    window_next[i] = w[j];
            end
        end

        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            cmd_bytes[8*i +: 8] = w[i];
        end
    end

    assign cmd_push          = take && (n != '0 || item.in_last);
    assign cmd_ctrl.use_repl = use_repl;
    assign cmd_ctrl.last     = item.in_last;
    assign cmd_n             = n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (take)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            window_reg <= window_next;
    end

    // Window never rests full
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < LW'(MAX_PATTERN))
        else $error("window count reached its depth");

    // Last byte leaves an empty window
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.in_last |=> count_reg == '0)
        else $error("window not cleared after last byte");

endmodule

// ===== sv/sfr_queue.sv =====
// ============================================================================
// sfr_queue: command queue between front and back
// Small first-in first-out buffer of packed command words.
// ============================================================================
module sfr_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wr_word,
    input  logic             rd,
    output logic [WIDTH-1:0] head,
    output logic             q_empty,
    output logic             q_full
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_wr;
    logic             do_rd;

    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == CW'(DEPTH));
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_word;
    end

endmodule

// ===== sv/sfr_back.sv =====
// ============================================================================
// sfr_back: command execution
// Step through the head command one byte per beat into the result register.
// ============================================================================
module sfr_back
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN = 8,
    parameter int MAX_REPLACE = 8,
    localparam int MAX_OUT = (MAX_PATTERN > MAX_REPLACE) ? MAX_PATTERN : MAX_REPLACE,
    localparam int NW      = $clog2(MAX_OUT + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     head_valid,
    input  cmd_ctrl_t                head_ctrl,
    input  logic [NW-1:0]            head_n,
    input  logic [MAX_PATTERN*8-1:0] head_bytes,
    input  logic [63:0]              replace_bytes,
    output logic                     head_done,
    output out_t                     result,
    output logic                     empty,
    input  logic                     pop
);

    logic [NW-1:0] idx_reg;
    logic [NW-1:0] idx_next;
    logic          ov_reg;
    out_t          out_reg;
    out_t          out_next;
    logic          load;
    logic          fire;
    logic          final_beat;
    logic [7:0]    ch;

    assign load       = !ov_reg || pop;
    assign fire       = head_valid && load;
    assign final_beat = (head_n == '0) || (NW'(idx_reg + 1'b1) == head_n);
    assign head_done  = fire && final_beat;

    always_comb
    begin
        ch = 8'h00;
        if (head_ctrl.use_repl)
        begin
            for (int i = 0; i < MAX_REPLACE; i++)
            begin
                if (int'(idx_reg) == i)
                    ch = reg_byte(replace_bytes, i);
            end
        end
        else
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                if (int'(idx_reg) == i)
                    ch = head_bytes[8*i +: 8];
            end
        end

        out_next.out_char  = (head_n == '0) ? 8'h00 : ch;
        out_next.out_empty = (head_n == '0);
        out_next.out_last  = head_ctrl.last && final_beat;

        idx_next = idx_reg;
        if (fire)
            idx_next = final_beat ? '0 : idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg  <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (fire)
                ov_reg <= 1'b1;
            else if (pop)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_reg <= out_next;
    end

    assign result = out_reg;
    assign empty  = !ov_reg;

    // Byte index stays inside the head command
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid && head_n != '0 |-> idx_reg < head_n)
        else $error("byte index ran past the command");

endmodule

// ===== sv/stream_find_replace.sv =====
// ============================================================================
// stream_find_replace: streaming find and replace over a byte stream
// Replaces each leftmost, non-overlapping occurrence of a pattern of up to
// MAX_PATTERN bytes with a replacement of up to MAX_REPLACE bytes.
// ============================================================================
// Flow: the command for a beat enters the queue at the accepting edge, and the
//   back loads the result register from the queue head once that register is
//   free or being popped.
// Throughput: one input beat per cycle while full is low; one result beat per
//   cycle while results are popped. A beat that yields k results holds the back
//   until all k are out, and the input stalls once the two-entry queue is full.
// Reset: rst_n clears the registers, the window count, the queue and the
//   result valid flag at once; window bytes stay undefined until written.
// ============================================================================
module stream_find_replace
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN = 8,
    parameter int MAX_REPLACE = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration writes
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    // input beats
    input  logic                  push,
    output logic                  full,
    input  in_t                   item,
    // result beats
    output logic                  empty,
    input  logic                  pop,
    output out_t                  result
);

    localparam int MAX_OUT = (MAX_PATTERN > MAX_REPLACE) ? MAX_PATTERN : MAX_REPLACE;
    localparam int NW      = $clog2(MAX_OUT + 1);
    localparam int CMD_W   = $bits(cmd_ctrl_t) + NW + MAX_PATTERN * 8;

    // ------------------------------------------------------------------
    // Configuration registers: the user must write them only while the block is
    // idle (the block does not enforce this), so front and back read them directly.
    // ------------------------------------------------------------------
    logic [3:0]  pattern_len_reg;
    logic [63:0] pattern_bytes_reg;
    logic [3:0]  replace_len_reg;
    logic [63:0] replace_bytes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_len_reg   <= '0;
            pattern_bytes_reg <= '0;
            replace_len_reg   <= '0;
            replace_bytes_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_PATTERN_LEN:   pattern_len_reg   <= wr_data[3:0];
                REG_PATTERN_BYTES: pattern_bytes_reg <= wr_data;
                REG_REPLACE_LEN:   replace_len_reg   <= wr_data[3:0];
                REG_REPLACE_BYTES: replace_bytes_reg <= wr_data;
                default:           ; // drop writes to unused indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Front: take a beat whenever the command queue has room.
    // ------------------------------------------------------------------
    logic                     take;
    logic                     q_push;
    cmd_ctrl_t                q_ctrl;
    logic [NW-1:0]            q_n;
    logic [MAX_PATTERN*8-1:0] q_bytes;

    assign take = push && !full;

    sfr_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_REPLACE (MAX_REPLACE)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .item          (item),
        .pattern_len   (pattern_len_reg),
        .pattern_bytes (pattern_bytes_reg),
        .replace_len   (replace_len_reg),
        .cmd_push      (q_push),
        .cmd_ctrl      (q_ctrl),
        .cmd_n         (q_n),
        .cmd_bytes     (q_bytes)
    );

    // ------------------------------------------------------------------
    // Command queue: decouples the front from result back-pressure.
    // ------------------------------------------------------------------
    logic [CMD_W-1:0]         q_head;
    logic                     q_empty;
    logic                     q_full;
    logic                     q_pop;
    cmd_ctrl_t                h_ctrl;
    logic [NW-1:0]            h_n;
    logic [MAX_PATTERN*8-1:0] h_bytes;

    sfr_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wr_word ({q_ctrl, q_n, q_bytes}),
        .rd      (q_pop),
        .head    (q_head),
        .q_empty (q_empty),
        .q_full  (q_full)
    );

    assign full = q_full;
    assign {h_ctrl, h_n, h_bytes} = q_head;

    // ------------------------------------------------------------------
    // Back: one result beat per cycle from the head command, while results are popped.
    // ------------------------------------------------------------------
    sfr_back #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_REPLACE (MAX_REPLACE)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (!q_empty),
        .head_ctrl     (h_ctrl),
        .head_n        (h_n),
        .head_bytes    (h_bytes),
        .replace_bytes (replace_bytes_reg),
        .head_done     (q_pop),
        .result        (result),
        .empty         (empty),
        .pop           (pop)
    );

    // A result without a byte only ever closes the text
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.out_empty |-> result.out_last)
        else $error("bare end mark on a non-final result");

    // A queued command with no bytes must be the end of the text
    a_no_idle_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty && h_n == '0 |-> h_ctrl.last)
        else $error("empty command queued without end mark");

    // A replacement burst never exceeds the replacement depth
    a_repl_len: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && q_ctrl.use_repl |-> q_n <= NW'(MAX_REPLACE))
        else $error("replacement burst too long");

endmodule

// ===== tb/stream_find_replace_tb.sv =====
// ============================================================================
// stream_find_replace_tb: self-checking bench for the stream find/replace
// Drives byte texts through the queue-style ports under several pattern and
// replacement settings, predicts every result beat and compares each field.
// ============================================================================
module stream_find_replace_tb;
    import sfr_pkg::*;

    localparam int PATTERN_MAX   = 8;
    localparam int REPLACE_MAX   = 8;
    // An index past the register map; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;
    localparam int SETTLE_CYCLES = 10;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_ITEMS  = 280;
    localparam int QUIET_TAIL    = 60;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the registers and the pending window,
    // turns each accepted text byte into the result beats it should cause and
    // checks the beats that come out, oldest first.
    // ------------------------------------------------------------------------
    class replace_scoreboard;
        logic [3:0]  pat_len   = '0;
        logic [63:0] pat_bytes = '0;
        logic [3:0]  rep_len   = '0;
        logic [63:0] rep_bytes = '0;
        logic [7:0]  win [PATTERN_MAX] = '{default: 8'h00};
        int unsigned win_count = 0;
        out_t        expected_text [$];
        int unsigned failures  = 0;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
            case (idx)
                REG_PATTERN_LEN:   pat_len   = data[3:0];
                REG_PATTERN_BYTES: pat_bytes = data;
                REG_REPLACE_LEN:   rep_len   = data[3:0];
                REG_REPLACE_BYTES: rep_bytes = data;
                default: ;
            endcase
        endfunction

        function void queue_char(logic [7:0] c);
            expected_text.push_back('{out_char: c, out_empty: 1'b0, out_last: 1'b0});
        endfunction

        function void drop_front(int unsigned k);
            if (k >= win_count)
                win_count = 0;
            else
            begin
                for (int i = 0; i < win_count - k; i++)
                    win[i] = win[i + k];
                win_count -= k;
            end
        endfunction

        function void note_char(in_t beat);
            int unsigned plen;
            int unsigned rlen;
            int unsigned keep;
            int unsigned cut;
            int unsigned queued_at_start;
            bit          hit;
            // lengths above the maximum saturate
            plen = (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
            rlen = (rep_len > REPLACE_MAX) ? REPLACE_MAX : rep_len;
            queued_at_start = expected_text.size();
            if (win_count >= PATTERN_MAX)
                win_count = PATTERN_MAX - 1;
            win[win_count] = beat.in_char;
            win_count++;
            if (win_count > plen)
            begin
                // window overfull (pass through, or pattern shortened):
                // release the oldest bytes unmatched, no compare this beat
                keep = (plen != 0) ? plen - 1 : 0;
                cut  = win_count - keep;
                for (int i = 0; i < cut; i++)
                    queue_char(win[i]);
                drop_front(cut);
            end
            else if (win_count == plen)
            begin
                hit = 1'b1;
                for (int i = 0; i < plen; i++)
                    if (win[i] != pat_bytes[8*i +: 8])
                        hit = 1'b0;
                if (hit)
                begin
                    for (int i = 0; i < rlen; i++)
                        queue_char(rep_bytes[8*i +: 8]);
                    win_count = 0;
                end
                else
                begin
                    queue_char(win[0]);
                    drop_front(1);
                end
            end
            if (beat.in_last)
            begin
                // flush the remainder; a text that ends on nothing still
                // gets an end-mark beat of its own
                for (int i = 0; i < win_count; i++)
                    queue_char(win[i]);
                win_count = 0;
                if (expected_text.size() == queued_at_start)
                    expected_text.push_back('{out_char: 8'h00, out_empty: 1'b1,
                                              out_last: 1'b1});
                else
                    expected_text[expected_text.size() - 1].out_last = 1'b1;
            end
        endfunction

        function void check_beat(out_t got);
            out_t want;
            if (expected_text.size() == 0)
            begin
                $error("unexpected result beat: out_char %02h out_empty %0b out_last %0b",
                       got.out_char, got.out_empty, got.out_last);
                failures++;
                return;
            end
            want = expected_text.pop_front();
            if (got.out_char !== want.out_char)
            begin
                $error("out_char: expected %02h, actual %02h", want.out_char, got.out_char);
                failures++;
            end
            if (got.out_empty !== want.out_empty)
            begin
                $error("out_empty: expected %0b, actual %0b", want.out_empty, got.out_empty);
                failures++;
            end
            if (got.out_last !== want.out_last)
            begin
                $error("out_last: expected %0b, actual %0b", want.out_last, got.out_last);
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  wr_index = '0;
    logic [CFG_DATA_W-1:0] wr_data  = '0;
    logic                  push     = 1'b0;
    logic                  full;
    in_t                   item     = '0;
    logic                  empty;
    logic                  pop      = 1'b0;
    out_t                  result;

    replace_scoreboard board = new();

    // Idling controls shared between the stimulus and the result sink
    int unsigned feed_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    bit          hold_request  = 1'b0;
    int unsigned items_sent    = 0;

    // Mirror of the current pattern, used to build texts that hit it
    int unsigned cur_plen    = 0;
    logic [63:0] cur_pattern = '0;

    always #5 clk = ~clk;

    stream_find_replace uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .push     (push),
        .full     (full),
        .item     (item),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

    // ------------------------------------------------------------------------
    // Driving tasks. Inputs change only just after a rising edge, and all
    // handshake signals are read there too, so they hold the values that the
    // edge itself saw.
    // ------------------------------------------------------------------------

    // Offer one text byte, with an occasional idle burst first; hold it until
    // the block takes it, then let the scoreboard predict its results.
    task automatic send_char(input logic [7:0] c, input logic last_flag);
        in_t beat;
        beat.in_char = c;
        beat.in_last = last_flag;
        if (feed_idle_pct != 0 && $urandom_range(0, 99) < feed_idle_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        push <= 1'b1;
        item <= beat;
        do
            @(posedge clk);
        while (full);
        board.note_char(beat);
        items_sent++;
    endtask

    // Drop push and wait until every predicted beat has come out, then give
    // a byte that caused no result time to clear the pipeline.
    task automatic settle();
        push <= 1'b0;
        while (board.expected_text.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write per edge; wr_en stays high across the burst.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        board.write_reg(idx, data);
    endtask

    // Load a full setting; only ever called with the block idle.
    task automatic load_settings(input logic [3:0] pl, input logic [63:0] pb,
                                 input logic [3:0] rl, input logic [63:0] rb);
        write_reg(REG_PATTERN_LEN, 64'(pl));
        write_reg(REG_PATTERN_BYTES, pb);
        write_reg(REG_REPLACE_LEN, 64'(rl));
        write_reg(REG_REPLACE_BYTES, rb);
        write_reg(REG_SPARE, {$urandom, $urandom});
        wr_en <= 1'b0;
        cur_plen    = (pl > PATTERN_MAX) ? PATTERN_MAX : pl;
        cur_pattern = pb;
    endtask

    // Build a random text biased towards the current pattern: whole copies,
    // broken prefixes, loose pattern bytes and plain noise. Close it with the
    // end mark when asked; an open text runs on into the next setting.
    task automatic send_text(input bit close);
        logic [7:0]  text [$];
        int unsigned len;
        int unsigned piece;
        int unsigned cut;
        len = $urandom_range(1, 24);
        while (text.size() < len)
        begin
            piece = $urandom_range(0, 9);
            if (piece < 4 && cur_plen != 0)
            begin
                cut = (piece == 0) ? $urandom_range(1, cur_plen) : cur_plen;
                for (int j = 0; j < cut; j++)
                    text.push_back(cur_pattern[8*j +: 8]);
            end
            else if (piece < 7 && cur_plen != 0)
                text.push_back(cur_pattern[8*$urandom_range(0, cur_plen - 1) +: 8]);
            else
                text.push_back(8'($urandom));
        end
        foreach (text[i])
            send_char(text[i], close && (i == text.size() - 1));
    endtask

    // ------------------------------------------------------------------------
    // Result sink: check every beat taken, and drive pop with random stall
    // bursts. A long hold on request lets the block fill and stall its input.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned hold_left;
        logic        next_pop;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                board.check_beat(result);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                next_pop = 1'b0;
            end
            else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct)
            begin
                hold_left = $urandom_range(0, 10);
                next_pop  = 1'b0;
            end
            else
                next_pop = 1'b1;
            pop <= next_pop;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: directed texts first, then random settings and texts
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned directed_items;
        int unsigned phase;
        int unsigned budget;
        logic [3:0]  pl;
        logic [3:0]  rl;
        logic [63:0] pb;
        logic [63:0] rb;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting is an empty pattern: bytes pass straight through,
        // zero byte and all-ones byte included
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h5A, 1'b1);
        settle();

        // "ab" with an empty replacement: a text that is exactly the pattern
        // leaves nothing but the end mark; then a miss followed by two hits
        load_settings(4'd2, 64'h6261, 4'd0, 64'h0);
        send_char(8'h61, 1'b0);
        send_char(8'h62, 1'b1);
        send_char(8'h78, 1'b0);
        send_char(8'h61, 1'b0);
        send_char(8'h62, 1'b0);
        send_char(8'h61, 1'b0);
        send_char(8'h62, 1'b1);
        settle();

        // Over-long lengths saturate: an eight-byte match gives eight
        // replacement bytes, then leave five bytes pending in the window
        load_settings(4'd15, 64'h0123_4567_89AB_CDEF, 4'd12, 64'hFEDC_BA98_7654_3210);
        for (int j = 0; j < 8; j++)
            send_char(cur_pattern[8*j +: 8], j == 7);
        for (int j = 0; j < 5; j++)
            send_char(cur_pattern[8*j +: 8], 1'b0);
        settle();

        // Shorten the pattern under the pending bytes: they all leave
        // unmatched on the next beat, then a one-byte hit closes the text
        load_settings(4'd1, 64'h71, 4'd3, 64'h00_7A79_78);
        send_char(8'h71, 1'b0);
        send_char(8'h71, 1'b1);
        settle();

        load_settings(4'd0, '1, 4'd8, '1);
        send_char(8'h00, 1'b1);
        settle();
        directed_items = items_sent;

        // Random phases; each one picks a setting and idling levels, then
        // sends texts. An open text at the end of a phase carries its window
        // into the next setting.
        phase = 0;
        while (items_sent < directed_items + RANDOM_ITEMS)
        begin
            case (phase)
                0:
                begin
                    pl = 4'd8;  pb = '1;  rl = 4'd15;  rb = {$urandom, $urandom};
                end
                1:
                begin
                    pl = 4'd15; pb = '0;  rl = 4'd0;   rb = '1;
                end
                default:
                begin
                    case ($urandom_range(0, 5))
                        0:       pl = 4'd0;
                        1:       pl = 4'd1;
                        2:       pl = 4'd2;
                        3:       pl = 4'd3;
                        4:       pl = 4'd8;
                        default: pl = 4'($urandom_range(0, 15));
                    endcase
                    pb = {$urandom, $urandom};
                    case ($urandom_range(0, 3))
                        0:       pb = '0;
                        1:       pb = '1;
                        // two-letter alphabet: self-overlapping patterns
                        2:       for (int j = 0; j < 8; j++)
                                     pb[8*j +: 8] = 8'h61 + 8'($urandom_range(0, 1));
                        default: ;
                    endcase
                    rl = 4'($urandom_range(0, 15));
                    rb = {$urandom, $urandom};
                end
            endcase
            load_settings(pl, pb, rl, rb);

            feed_idle_pct = 15 * $urandom_range(0, 2);
            sink_idle_pct = 15 * $urandom_range(0, 2);
            if (phase == 2)
            begin
                // keep offering bytes while the sink holds off for a long
                // stretch, so the queue fills and full is raised
                feed_idle_pct = 0;
                hold_request  = 1'b1;
            end

            budget = items_sent + $urandom_range(25, 45);
            while (items_sent < budget && items_sent < directed_items + RANDOM_ITEMS)
            begin
                if (items_sent + QUIET_TAIL >= directed_items + RANDOM_ITEMS)
                begin
                    feed_idle_pct = 0;
                    sink_idle_pct = 0;
                end
                send_text($urandom_range(0, 7) != 0);
            end
            settle();
            phase++;
        end

        // close whatever text is still open, then drain
        send_text(1'b1);
        settle();

        if (board.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin : watchdog
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/sfr_pkg.sv
sv/sfr_front.sv
sv/sfr_queue.sv
sv/sfr_back.sv
sv/stream_find_replace.sv
tb/stream_find_replace_tb.sv
